// ===== rtl/ean13_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ean13_pkg
// Shared types, constants and table lookups of the EAN-13 scanline decoder.
// ----------------------------------------------------------------------------
package ean13_pkg;

	localparam int unsigned RUN_W     = 11;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned NUM_W     = 14;
	localparam int unsigned Q_DEPTH   = 4;
	localparam logic [RUN_W-1:0] RUN_MAX   = 11'd2047;
	localparam logic [IDX_W-1:0] IDX_MAX   = 6'd63;
	localparam logic [IDX_W-1:0] LEFT_LO   = 6'd4;
	localparam logic [IDX_W-1:0] LEFT_HI   = 6'd27;
	localparam logic [IDX_W-1:0] RIGHT_LO  = 6'd33;
	localparam logic [IDX_W-1:0] RIGHT_HI  = 6'd56;
	localparam logic [3:0]       RIGHT_POS = 4'd6;
	localparam logic [3:0]       POS_LAST  = 4'd12;
	localparam logic [7:0] THRESHOLD_RST   = 8'd125;
	localparam logic [7:0] MODULE_RST      = 8'd17;
	localparam logic [7:0] MODULE_MIN      = 8'd2;

	// configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_MODULE    = 1'b1;

	// one queued run-boundary or end-of-line event
	typedef struct packed {
		logic [RUN_W-1:0] run_len;
		logic [3:0]       pos;
		logic [1:0]       sub;
		logic             left;
		logic             close;
		logic             eol;
	} q_entry_t;

	typedef struct packed {
		logic       found;
		logic [3:0] digit;
		logic       g_set;
	} match_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_STORE,
		BK_EMIT
	} back_state_t;

	// widths written first-run first, run 0 in the top bits
	localparam logic [11:0] L_TAB [10] = '{
		{3'd3, 3'd2, 3'd1, 3'd1}, {3'd2, 3'd2, 3'd2, 3'd1}, {3'd2, 3'd1, 3'd2, 3'd2},
		{3'd1, 3'd4, 3'd1, 3'd1}, {3'd1, 3'd1, 3'd3, 3'd2}, {3'd1, 3'd2, 3'd3, 3'd1},
		{3'd1, 3'd1, 3'd1, 3'd4}, {3'd1, 3'd3, 3'd1, 3'd2}, {3'd1, 3'd2, 3'd1, 3'd3},
		{3'd3, 3'd1, 3'd1, 3'd2}
	};
	localparam logic [11:0] G_TAB [10] = '{
		{3'd1, 3'd1, 3'd2, 3'd3}, {3'd1, 3'd2, 3'd2, 3'd2}, {3'd2, 3'd2, 3'd1, 3'd2},
		{3'd1, 3'd1, 3'd4, 3'd1}, {3'd2, 3'd3, 3'd1, 3'd1}, {3'd1, 3'd3, 3'd2, 3'd1},
		{3'd4, 3'd1, 3'd1, 3'd1}, {3'd2, 3'd1, 3'd3, 3'd1}, {3'd3, 3'd1, 3'd2, 3'd1},
		{3'd2, 3'd1, 3'd1, 3'd3}
	};
	// parity of left symbol k in bit k
	localparam logic [5:0] PARITY_TAB [10] = '{
		6'b000000, 6'b110100, 6'b101100, 6'b011100, 6'b110010,
		6'b100110, 6'b001110, 6'b101010, 6'b011010, 6'b010110
	};

	function automatic match_t match_symbol(input logic [11:0] w);
		match_t r;
		r = '0;
		for (int d = 0; d < 10; d++) begin
			if (!r.found && w == L_TAB[d]) begin
				r.found = 1'b1;
				r.digit = 4'(d);
				r.g_set = 1'b0;
			end else if (!r.found && w == G_TAB[d]) begin
				r.found = 1'b1;
				r.digit = 4'(d);
				r.g_set = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic match_t match_parity(input logic [5:0] p);
		match_t r;
		r = '0;
		for (int d = 0; d < 10; d++) begin
			if (!r.found && p == PARITY_TAB[d]) begin
				r.found = 1'b1;
				r.digit = 4'(d);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ean13_scanline_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ean13_scanline_decoder
// EAN-13 scanline decoder: pixel stream in, 13 digit results per line out.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while the 4-entry event queue has room.
// Each run close inside a symbol takes the back end through a pop, 4 quotient
// steps and a symbol store, so closely spaced run edges can stall the input.
// End of line: the 13 results leave one per cycle while the receiver is ready,
// after queued events drain; the emit state loads each into the output register.
// Asynchronous active-low reset clears all control state and line stores.
module ean13_scanline_decoder import ean13_pkg::*; #(
	parameter int unsigned LINE_PIXELS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] pixel
	input  wire logic        s_tlast,   // end_of_line
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [3:0] position, [7:4] digit, [8] digit_found
	output logic             m_tlast    // last_digit
);

	logic [7:0] threshold_q;
	logic [7:0] module_q;
	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_valid;
	q_entry_t   q_wdata;
	q_entry_t   q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			module_q    <= MODULE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_wdata;
				CFG_MODULE:    module_q    <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	ean13_front #(
		.LINE_PIXELS(LINE_PIXELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.threshold(threshold_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	ean13_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rvalid(q_valid),
		.rdata (q_rdata)
	);

	ean13_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.module_width_halves(module_q),
		.q_valid            (q_valid),
		.q_rdata            (q_rdata),
		.q_pop              (q_pop),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tlast            (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/ean13_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ean13_front
// Thresholds pixels, tracks runs and queues run closes inside symbols and end of line.
// ----------------------------------------------------------------------------
module ean13_front import ean13_pkg::*; #(
	parameter int unsigned LINE_PIXELS = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] threshold,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] pixel
	input  wire logic       s_tlast,  // end_of_line
	input  wire logic       q_full,
	output logic            q_push,
	output q_entry_t        q_wdata
);

	localparam int unsigned CNT_W = $clog2(LINE_PIXELS + 1);

	logic             started_q;
	logic             level_q;
	logic [RUN_W-1:0] run_len_q;
	logic [IDX_W-1:0] run_idx_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             level;
	logic             closing;
	logic             eol_eff;
	logic             in_left;
	logic             in_right;
	logic [CNT_W-1:0] cnt_nx;
	logic [IDX_W-1:0] off_left;
	logic [IDX_W-1:0] off_right;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		level     = s_tdata >= threshold;
		closing   = started_q && (level != level_q);
		cnt_nx    = (started_q ? cnt_q : '0) + CNT_W'(1);
		eol_eff   = s_tlast || (cnt_nx == CNT_W'(LINE_PIXELS));
		in_left   = run_idx_q inside {[LEFT_LO:LEFT_HI]};
		in_right  = run_idx_q inside {[RIGHT_LO:RIGHT_HI]};
		off_left  = run_idx_q - LEFT_LO;
		off_right = run_idx_q - RIGHT_LO;

		q_wdata         = '0;
		q_wdata.run_len = run_len_q;
		q_wdata.left    = in_left;
		q_wdata.close   = closing && (in_left || in_right);
		q_wdata.eol     = eol_eff;
		if (in_left) begin
			q_wdata.pos = 4'(off_left >> 2);
			q_wdata.sub = off_left[1:0];
		end else begin
			q_wdata.pos = RIGHT_POS + 4'(off_right >> 2);
			q_wdata.sub = off_right[1:0];
		end
		q_push = accept && (q_wdata.close || eol_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			level_q   <= 1'b0;
			run_len_q <= '0;
			run_idx_q <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			started_q <= !eol_eff;
			level_q   <= level;
			cnt_q     <= cnt_nx;
			if (!started_q) begin
				run_len_q <= RUN_W'(1);
				run_idx_q <= '0;
			end else if (!closing) begin
				if (run_len_q != RUN_MAX)
					run_len_q <= run_len_q + RUN_W'(1);
			end else begin
				run_len_q <= RUN_W'(1);
				if (run_idx_q != IDX_MAX)
					run_idx_q <= run_idx_q + IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ean13_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ean13_queue
// Small first-in first-out queue of run events between front and back.
// ----------------------------------------------------------------------------
module ean13_queue import ean13_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wdata,
	output logic          full,
	input  wire logic     pop,
	output logic          rvalid,
	output q_entry_t      rdata
);

	localparam int unsigned AW = $clog2(Q_DEPTH);
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	q_entry_t        mem_q [Q_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CW'(Q_DEPTH);
	assign rvalid  = count_q != '0;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + AW'(1);
			if (do_pop)
				rd_q <= rd_q + AW'(1);
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(Q_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

// ===== rtl/ean13_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ean13_back
// Quantizes closed runs, matches symbols and streams out the 13 digits.
// ----------------------------------------------------------------------------
module ean13_back import ean13_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  module_width_halves,
	input  wire logic        q_valid,
	input  wire q_entry_t    q_rdata,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [3:0] position, [7:4] digit, [8] digit_found
	output logic             m_tlast   // last_digit
);

	back_state_t      state_q;
	back_state_t      state_nx;
	q_entry_t         ent_q;
	logic [NUM_W-1:0] rem_q;
	logic [11:0]      dv_q;
	logic [1:0]       step_q;
	logic [2:0]       quo_q;
	logic             sat_q;
	logic [2:0]       width_q [4];
	logic [3:0]       digit_q [12];
	logic [11:0]      found_q;
	logic [5:0]       parity_q;
	logic [3:0]       emit_pos_q;
	logic             tvalid_q;
	logic [3:0]       out_pos_q;
	logic [3:0]       out_digit_q;
	logic             out_found_q;
	logic             out_last_q;

	logic [7:0]       m_eff;
	logic             ge;
	logic [2:0]       q_mod;
	logic [11:0]      sym_w;
	match_t           sym_m;
	match_t           first_m;
	logic             out_ld;
	logic [3:0]       slot;

	assign m_eff    = (module_width_halves < MODULE_MIN) ? MODULE_MIN : module_width_halves;
	assign ge       = rem_q >= {2'b00, dv_q};
	assign q_mod    = sat_q ? 3'd7 : quo_q;
	assign out_ld   = (state_q == BK_EMIT) && (!tvalid_q || m_tready);
	assign slot     = emit_pos_q - 4'd1;
	assign m_tvalid = tvalid_q;
	assign m_tdata  = {7'b0, out_found_q, out_digit_q, out_pos_q};
	assign m_tlast  = out_last_q;

	// symbol widths with the run just quantized in place
	always_comb begin
		sym_w = {width_q[0], width_q[1], width_q[2], width_q[3]};
		case (ent_q.sub)
			2'd0:    sym_w[11:9] = q_mod;
			2'd1:    sym_w[8:6]  = q_mod;
			2'd2:    sym_w[5:3]  = q_mod;
			default: sym_w[2:0]  = q_mod;
		endcase
		sym_m   = match_symbol(sym_w);
		first_m = (&found_q[5:0]) ? match_parity(parity_q) : '0;
	end

	always_comb begin
		state_nx = state_q;
		q_pop    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_rdata.close)
						state_nx = BK_DIV;
					else if (q_rdata.eol)
						state_nx = BK_EMIT;
				end
			end
			BK_DIV: begin
				if (step_q == 2'd3)
					state_nx = BK_STORE;
			end
			BK_STORE: begin
				state_nx = ent_q.eol ? BK_EMIT : BK_IDLE;
			end
			BK_EMIT: begin
				if (out_ld && emit_pos_q == POS_LAST)
					state_nx = BK_IDLE;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nx;
	end

	// event capture and shift-subtract quotient, saturation checked first
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q  <= q_rdata;
			rem_q  <= {1'b0, q_rdata.run_len, 2'b00} + NUM_W'(m_eff);
			dv_q   <= {m_eff, 4'b0000};
			step_q <= 2'd0;
		end else if (state_q == BK_DIV) begin
			if (ge)
				rem_q <= rem_q - {2'b00, dv_q};
			if (step_q == 2'd0)
				sat_q <= ge;
			else
				quo_q <= {quo_q[1:0], ge};
			dv_q   <= dv_q >> 1;
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				width_q[i] <= '0;
			for (int i = 0; i < 12; i++)
				digit_q[i] <= '0;
			found_q    <= '0;
			parity_q   <= '0;
			emit_pos_q <= '0;
		end else if (state_q == BK_STORE) begin
			width_q[ent_q.sub] <= q_mod;
			if (ent_q.sub == 2'd3 && sym_m.found) begin
				digit_q[ent_q.pos] <= sym_m.digit;
				found_q[ent_q.pos] <= 1'b1;
				if (ent_q.left)
					parity_q[ent_q.pos[2:0]] <= sym_m.g_set;
			end
		end else if (out_ld) begin
			if (emit_pos_q == POS_LAST) begin
				for (int i = 0; i < 4; i++)
					width_q[i] <= '0;
				for (int i = 0; i < 12; i++)
					digit_q[i] <= '0;
				found_q    <= '0;
				parity_q   <= '0;
				emit_pos_q <= '0;
			end else begin
				emit_pos_q <= emit_pos_q + 4'd1;
			end
		end
	end

	// output register parts the back from the downstream stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= 1'b0;
		else if (out_ld)
			tvalid_q <= 1'b1;
		else if (m_tready)
			tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_pos_q   <= emit_pos_q;
			out_last_q  <= emit_pos_q == POS_LAST;
			if (emit_pos_q == 4'd0) begin
				out_digit_q <= first_m.digit;
				out_found_q <= first_m.found;
			end else begin
				out_digit_q <= digit_q[slot];
				out_found_q <= found_q[slot];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(tvalid_q && out_last_q) |-> (out_pos_q == POS_LAST))
		else $error("last digit flag off position 12");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && emit_pos_q == POS_LAST) |=> (found_q == '0 && parity_q == '0))
		else $error("line stores not cleared after last digit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_STORE) |-> ($past(state_q) == BK_DIV && $past(step_q) == 2'd3))
		else $error("symbol store without finished quotient");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the EAN-13 scanline decoder. Synthetic scanlines
// (clean codes, damaged and truncated codes, random bar widths and plain
// noise) are streamed in under random bursts and output back-pressure, and
// every digit transaction is compared with an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_top;
	import ean13_pkg::*;

	localparam int unsigned LINE_PX = 1024;

	typedef struct packed {
		logic [3:0] pos;
		logic [3:0] digit;
		logic       found;
		logic       last;
	} digit_res_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       eol;
		logic       blank;
	} dir_row_t;

	typedef enum int {
		LN_CLEAN,
		LN_DAMAGED,
		LN_G_RIGHT,
		LN_TRUNC,
		LN_RANDOM_WIDTHS
	} line_kind_t;

	typedef enum int {
		RDY_FULL,
		RDY_MOSTLY,
		RDY_SPARSE,
		RDY_PERIODIC
	} rdy_mode_t;

	// bar/space widths per digit, first run in the top nibble: [digit][0 = L/R, 1 = G]
	localparam logic [15:0] SYM_TAB [10][2] = '{
		'{16'h3211, 16'h1123}, '{16'h2221, 16'h1222}, '{16'h2122, 16'h2212},
		'{16'h1411, 16'h1141}, '{16'h1132, 16'h2311}, '{16'h1231, 16'h1321},
		'{16'h1114, 16'h4111}, '{16'h1312, 16'h2131}, '{16'h1213, 16'h3121},
		'{16'h3112, 16'h2113}
	};
	// bit k set when left symbol k uses the G set
	localparam logic [5:0] PAR_TAB [10] = '{
		6'b000000, 6'b110100, 6'b101100, 6'b011100, 6'b110010,
		6'b100110, 6'b001110, 6'b101010, 6'b011010, 6'b010110
	};

	// short lines: no symbol can close, so every digit is unmatched
	localparam dir_row_t DIR_ROWS [20] = '{
		'{8'd0, 1'b1, 1'b1}, '{8'd255, 1'b1, 1'b1},
		'{8'd124, 1'b0, 1'b0}, '{8'd125, 1'b1, 1'b1},
		'{8'd125, 1'b0, 1'b0}, '{8'd124, 1'b0, 1'b0},
		'{8'd125, 1'b0, 1'b0}, '{8'd124, 1'b1, 1'b1},
		'{8'd0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0},
		'{8'd0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0},
		'{8'd0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0},
		'{8'd0, 1'b0, 1'b0}, '{8'd255, 1'b1, 1'b1},
		'{8'hAA, 1'b0, 1'b0}, '{8'h55, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_THRESHOLD;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] pixel
	logic        s_tlast = 1'b0;   // end_of_line
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [3:0] position, [7:4] digit, [8] digit_found
	logic        m_tlast;          // last_digit

	// decoder model state
	logic [7:0]  dec_thr;
	logic [7:0]  dec_mod;
	logic        dec_level;
	logic        dec_started;
	int unsigned dec_run;
	int unsigned dec_idx;
	int unsigned dec_pix;
	logic [2:0]  dec_w [4];
	logic [3:0]  dec_digit [12];
	logic        dec_found [12];
	logic [5:0]  dec_par;
	digit_res_t  line_res [13];

	digit_res_t  exp_digits [$];
	logic [7:0]  line_px [$];
	int          err_count = 0;
	int          px_sent = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	logic [7:0]  rdy_cnt = 8'd0;
	rdy_mode_t   rdy_mode = RDY_FULL;

	ean13_scanline_decoder #(
		.LINE_PIXELS(LINE_PX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic void clear_line();
		for (int i = 0; i < 4; i++)
			dec_w[i] = 3'd0;
		for (int i = 0; i < 12; i++) begin
			dec_digit[i] = 4'd0;
			dec_found[i] = 1'b0;
		end
		dec_par = 6'd0;
		dec_idx = 0;
		dec_run = 0;
		dec_pix = 0;
	endfunction

	function automatic void match_widths(input int slot, input bit left);
		logic [15:0] w;
		w = {1'b0, dec_w[0], 1'b0, dec_w[1], 1'b0, dec_w[2], 1'b0, dec_w[3]};
		for (int d = 0; d < 10; d++) begin
			for (int t = 0; t < 2; t++) begin
				if (w == SYM_TAB[d][t]) begin
					dec_digit[slot] = d[3:0];
					dec_found[slot] = 1'b1;
					if (left)
						dec_par[slot] = t[0];
					return;
				end
			end
		end
	endfunction

	function automatic void close_run();
		int unsigned m;
		int unsigned q;
		m = (dec_mod < 8'd2) ? 2 : dec_mod;
		q = (4 * dec_run + m) / (2 * m);
		if (q > 7)
			q = 7;
		if (dec_idx >= 4 && dec_idx <= 27) begin
			dec_w[(dec_idx - 4) % 4] = q[2:0];
			if ((dec_idx - 4) % 4 == 3)
				match_widths((dec_idx - 4) / 4, 1'b1);
		end else if (dec_idx >= 33 && dec_idx <= 56) begin
			dec_w[(dec_idx - 33) % 4] = q[2:0];
			if ((dec_idx - 33) % 4 == 3)
				match_widths(6 + (dec_idx - 33) / 4, 1'b0);
		end
		if (dec_idx < 63)
			dec_idx++;
	endfunction

	// returns 1 when the pixel ends a line; the 13 digits are then in line_res
	function automatic bit step_decoder(input logic [7:0] px, input logic eol_in);
		logic       lvl;
		logic       eol;
		logic [3:0] first;
		logic       first_ok;
		logic       all_left;
		lvl = (px >= dec_thr);
		eol = eol_in;
		if (!dec_started) begin
			clear_line();
			dec_started = 1'b1;
			dec_level = lvl;
			dec_run = 1;
		end else if (lvl == dec_level) begin
			if (dec_run < 2047)
				dec_run++;
		end else begin
			close_run();
			dec_level = lvl;
			dec_run = 1;
		end
		if (dec_pix < LINE_PX)
			dec_pix++;
		if (dec_pix >= LINE_PX)
			eol = 1'b1;
		if (!eol)
			return 1'b0;
		first = 4'd0;
		first_ok = 1'b0;
		all_left = 1'b1;
		for (int k = 0; k < 6; k++)
			if (!dec_found[k])
				all_left = 1'b0;
		if (all_left) begin
			for (int d = 0; d < 10; d++) begin
				if (!first_ok && dec_par == PAR_TAB[d]) begin
					first = d[3:0];
					first_ok = 1'b1;
				end
			end
		end
		for (int p = 0; p < 13; p++) begin
			line_res[p].pos = p[3:0];
			line_res[p].digit = (p == 0) ? first : dec_digit[p - 1];
			line_res[p].found = (p == 0) ? first_ok : dec_found[p - 1];
			line_res[p].last = (p == 12);
		end
		dec_started = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] grey_for(input logic lvl);
		if (lvl)
			return 8'($urandom_range(dec_thr, 255));
		return 8'($urandom_range(0, dec_thr - 1));
	endfunction

	function automatic int run_pixels(input int q);
		int m;
		int n;
		m = (dec_mod < 8'd2) ? 2 : dec_mod;
		n = (q * m + 1) / 2;
		// jitter around the nominal width when a module spans several pixels
		if (m >= 6 && $urandom_range(0, 3) == 0)
			n = n + ($urandom_range(0, 1) ? 1 : -1);
		if (n < 1)
			n = 1;
		return n;
	endfunction

	task automatic add_run(input logic lvl, input int n);
		repeat (n)
			line_px.push_back(grey_for(lvl));
	endtask

	task automatic build_code_line(input line_kind_t kind);
		int          mods [$];
		int          first;
		int          dg;
		int          sym;
		int          cut;
		logic [15:0] tab;
		logic        lvl;
		mods = {1, 1, 1};
		first = $urandom_range(0, 9);
		for (int k = 0; k < 6; k++) begin
			dg = $urandom_range(0, 9);
			tab = SYM_TAB[dg][PAR_TAB[first][k]];
			for (int j = 3; j >= 0; j--)
				mods.push_back(int'(tab[j*4 +: 4]));
		end
		repeat (5)
			mods.push_back(1);
		for (int k = 0; k < 6; k++) begin
			dg = $urandom_range(0, 9);
			tab = SYM_TAB[dg][(kind == LN_G_RIGHT) ? $urandom_range(0, 1) : 0];
			for (int j = 3; j >= 0; j--)
				mods.push_back(int'(tab[j*4 +: 4]));
		end
		mods.push_back(1);
		mods.push_back(1);
		mods.push_back(1);
		if (kind == LN_DAMAGED) begin
			sym = $urandom_range(0, 11);
			mods[3 + 4 * sym + ((sym >= 6) ? 5 : 0) + $urandom_range(0, 3)] =
				$urandom_range(1, 7);
		end else if (kind == LN_TRUNC) begin
			cut = $urandom_range(4, 57);
			while (mods.size() > cut)
				mods.delete(mods.size() - 1);
		end else if (kind == LN_RANDOM_WIDTHS) begin
			// mostly narrow runs, now and then one wide enough to saturate
			foreach (mods[i])
				mods[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10) :
					$urandom_range(1, 4);
		end
		line_px.delete();
		add_run(1'b1, $urandom_range(1, 12));
		lvl = 1'b0;
		foreach (mods[i]) begin
			add_run(lvl, run_pixels(mods[i]));
			lvl = ~lvl;
		end
		add_run(lvl, $urandom_range(1, 12));
	endtask

	task automatic build_noise(input int n);
		line_px.delete();
		repeat (n)
			line_px.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_pixel(input logic [7:0] px, input logic eol, input logic blank);
		if (burst_left == 0) begin
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= eol;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		px_sent++;
		if (step_decoder(px, eol)) begin
			for (int p = 0; p < 13; p++) begin
				if (blank) begin
					line_res[p].digit = 4'd0;
					line_res[p].found = 1'b0;
				end
				exp_digits.push_back(line_res[p]);
			end
		end
	endtask

	task automatic send_line();
		foreach (line_px[i])
			send_pixel(line_px[i], i == line_px.size() - 1, 1'b0);
	endtask

	// hold the input off until every digit of the previous lines is out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (exp_digits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(input int thr, input int mod);
		cfg_we <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_wdata <= thr[7:0];
		@(posedge clk);
		dec_thr = thr[7:0];
		cfg_index <= CFG_MODULE;
		cfg_wdata <= mod[7:0];
		@(posedge clk);
		dec_mod = mod[7:0];
		cfg_we <= 1'b0;
	endtask

	task automatic pick_line();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			build_code_line(LN_CLEAN);
		else if (r < 60)
			build_code_line(LN_DAMAGED);
		else if (r < 70)
			build_code_line(LN_G_RIGHT);
		else if (r < 80)
			build_code_line(LN_TRUNC);
		else if (r < 88)
			build_code_line(LN_RANDOM_WIDTHS);
		else
			build_noise($urandom_range(1, 60));
		send_line();
	endtask

	// receiver back-pressure, pattern picked anew whenever the low seven counter bits are zero
	always @(posedge clk) begin
		rdy_cnt <= rdy_cnt + 8'd1;
		if (rdy_cnt[6:0] == 7'd0)
			rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
		case (rdy_mode)
			RDY_FULL: m_tready <= 1'b1;
			RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
			RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (rdy_cnt[2:0] != 3'd0) && rdy_cnt[4];
		endcase
	end

	always @(posedge clk) begin
		digit_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_digits.size() == 0) begin
				report_error($sformatf("digit transaction with none pending, tdata %h",
					m_tdata));
			end else begin
				want = exp_digits.pop_front();
				if (m_tdata[3:0] != want.pos)
					report_error($sformatf("position got %0d want %0d", m_tdata[3:0],
						want.pos));
				if (m_tdata[7:4] != want.digit)
					report_error($sformatf("digit at %0d got %0d want %0d", want.pos,
						m_tdata[7:4], want.digit));
				if (m_tdata[8] != want.found)
					report_error($sformatf("digit_found at %0d got %0b want %0b",
						want.pos, m_tdata[8], want.found));
				if (m_tlast != want.last)
					report_error($sformatf("last_digit at %0d got %0b want %0b",
						want.pos, m_tlast, want.last));
				if (m_tdata[15:9] != 7'd0)
					report_error($sformatf("tdata padding at %0d got %h", want.pos,
						m_tdata[15:9]));
			end
		end
	end

	initial begin
		dec_thr = 8'd125;
		dec_mod = 8'd17;
		dec_level = 1'b0;
		dec_started = 1'b0;
		clear_line();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short lines at the reset settings, threshold edge included
		foreach (DIR_ROWS[i])
			send_pixel(DIR_ROWS[i].pixel, DIR_ROWS[i].eol, DIR_ROWS[i].blank);

		// one pixel per module
		wait_idle();
		write_cfg(128, 2);
		gaps_on = 1'b0;
		build_code_line(LN_CLEAN);
		send_line();
		gaps_on = 1'b1;
		build_code_line(LN_G_RIGHT);
		send_line();

		// every pixel is white, widest module
		wait_idle();
		write_cfg(0, 255);
		build_noise(30);
		send_line();

		// module width below the minimum behaves as two half pixels
		wait_idle();
		write_cfg(90, 1);
		build_code_line(LN_DAMAGED);
		send_line();

		while (px_sent < 400) begin
			wait_idle();
			write_cfg($urandom_range(1, 255), $urandom_range(2, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			pick_line();
		end

		s_tvalid <= 1'b0;
		while (exp_digits.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== ean13_scanline_decoder.f =====
rtl/ean13_pkg.sv
rtl/ean13_front.sv
rtl/ean13_queue.sv
rtl/ean13_back.sv
rtl/ean13_scanline_decoder.sv
tb/tb_top.sv
